### rtl/dosc_pkg.sv
// Shared types and constants for the damped oscillator scan block.
// Used by the controller, the datapath and the top level.
package dosc_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned OpW    = 33;
    localparam int unsigned ProdW  = 2 * OpW;
    localparam int unsigned DivW   = 49;
    localparam int unsigned InvW   = 17;
    localparam int unsigned CoefW  = 31;
    localparam int unsigned DivCnt = DivW;
    localparam int unsigned AddrW  = 4;

    localparam logic [AddrW-1:0] AddrStiffness = 4'h0;
    localparam logic [AddrW-1:0] AddrDamping   = 4'h4;
    localparam logic [AddrW-1:0] AddrTimeStep  = 4'h8;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SG_MUL   = 12'b0000_0000_0010,
        ST_SG_WB    = 12'b0000_0000_0100,
        ST_DIV      = 12'b0000_0000_1000,
        ST_SINV_MUL = 12'b0000_0001_0000,
        ST_SINV_WB  = 12'b0000_0010_0000,
        ST_S2_MUL   = 12'b0000_0100_0000,
        ST_S2_WB    = 12'b0000_1000_0000,
        ST_C_MUL    = 12'b0001_0000_0000,
        ST_C_WB     = 12'b0010_0000_0000,
        ST_MAC      = 12'b0100_0000_0000,
        ST_DONE     = 12'b1000_0000_0000
    } dosc_state_t;

    typedef struct packed {
        dosc_state_t op;
        logic        load;
        logic        start;
        logic        mac_issue;
        logic [1:0]  mac_idx;
        logic        mac_acc;
    } dosc_cmd_t;

    typedef struct packed {
        logic out_free;
    } dosc_status_t;

endpackage

### rtl/dosc_ctrl.sv
// Controller state machine of the damped oscillator scan block.
// Depends on dosc_pkg; drives the datapath through dosc_cmd_t.
module dosc_ctrl import dosc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_write,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_sequence_start,
    input  dosc_status_t status,
    output dosc_cmd_t    cmd
);

    dosc_state_t state_reg, state_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic [2:0]  mac_cnt_reg, mac_cnt_next;
    logic        coef_valid_reg, coef_valid_next;
    logic        accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        div_cnt_next    = div_cnt_reg;
        mac_cnt_next    = mac_cnt_reg;
        coef_valid_next = coef_valid_reg;
        cmd.op          = state_reg;
        cmd.load        = accept;
        cmd.start       = s_sequence_start;
        cmd.mac_issue   = (state_reg == ST_MAC) && (mac_cnt_reg != 3'd4);
        cmd.mac_idx     = mac_cnt_reg[1:0];
        cmd.mac_acc     = (state_reg == ST_MAC) && (mac_cnt_reg != 3'd0);
        if (cfg_write) begin
            coef_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                mac_cnt_next = 3'd0;
                if (accept) begin
                    state_next = (coef_valid_reg && !cfg_write) ? ST_MAC : ST_SG_MUL;
                end
            end
            ST_SG_MUL:   state_next = ST_SG_WB;
            ST_SG_WB: begin
                div_cnt_next = 6'd0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(DivCnt - 1)) begin
                    state_next = ST_SINV_MUL;
                end
            end
            ST_SINV_MUL: state_next = ST_SINV_WB;
            ST_SINV_WB:  state_next = ST_S2_MUL;
            ST_S2_MUL:   state_next = ST_S2_WB;
            ST_S2_WB:    state_next = ST_C_MUL;
            ST_C_MUL:    state_next = ST_C_WB;
            ST_C_WB: begin
                coef_valid_next = 1'b1;
                state_next      = ST_MAC;
            end
            ST_MAC: begin
                mac_cnt_next = mac_cnt_reg + 3'd1;
                if (mac_cnt_reg == 3'd4) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            div_cnt_reg    <= 6'd0;
            mac_cnt_reg    <= 3'd0;
            coef_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            div_cnt_reg    <= div_cnt_next;
            mac_cnt_reg    <= mac_cnt_next;
            coef_valid_reg <= coef_valid_next;
        end
    end

endmodule

### rtl/dosc_dp.sv
// Datapath of the damped oscillator scan block: coefficient derivation,
// restoring divider, three shared multipliers, state and output registers.
// Depends on dosc_pkg; commanded by dosc_ctrl.
module dosc_dp import dosc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dosc_cmd_t               cmd,
    output dosc_status_t            status,
    input  logic [WordW-1:0]        stiffness,
    input  logic [WordW-1:0]        damping,
    input  logic [WordW-1:0]        time_step,
    input  logic signed [WordW-1:0] s_sample_re,
    input  logic signed [WordW-1:0] s_sample_im,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [WordW-1:0] m_first_re,
    output logic signed [WordW-1:0] m_first_im,
    output logic signed [WordW-1:0] m_second_re,
    output logic signed [WordW-1:0] m_second_im,
    output logic                    m_saturated
);

    localparam logic signed [50:0] SMax = 51'sd2147483647;
    localparam logic signed [50:0] SMin = -51'sd2147483648;

    logic signed [OpW-1:0]   ma0, mb0, ma1, mb1, ma2, mb2;
    logic signed [ProdW-1:0] p0_reg, p1_reg, p2_reg;

    logic [InvW-1:0]  inv_reg;
    logic [CoefW-1:0] sinv_reg, s2inv_reg;
    logic signed [WordW-1:0] c12_reg, c22_reg;

    logic [DivW-1:0] den_reg, num_reg, rem_reg;
    logic [DivW:0]   rem_sh;
    logic            ge;

    logic signed [WordW-1:0] u_re_reg, u_im_reg;
    logic signed [WordW-1:0] x0r_reg, x0i_reg, x1r_reg, x1i_reg;
    logic signed [WordW-1:0] n_reg [4];
    logic [1:0]              idx_reg;
    logic                    clip_reg;
    logic                    m_valid_reg;
    logic signed [WordW-1:0] out_reg [4];
    logic                    sat_reg;

    logic [63:0] r0, r1;
    logic [47:0] t0, t1;
    logic [DivW-1:0] den_c;
    logic signed [49:0] d22;
    logic signed [WordW-1:0] x1s, us;
    logic signed [ProdW:0] sum;
    logic signed [50:0] rsum;
    logic out_free;

    assign r0 = p0_reg[63:0] + 64'd32768;
    assign r1 = p1_reg[63:0] + 64'd32768;
    assign t0 = r0[63:16];
    assign t1 = r1[63:16];
    assign den_c = DivW'(65536) + {1'b0, t0};
    assign d22 = 50'sd65536 - $signed({2'b00, t1});

    assign rem_sh = {rem_reg, num_reg[DivW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    assign sum  = {p0_reg[ProdW-1], p0_reg} + {p1_reg[ProdW-1], p1_reg}
                + {p2_reg[ProdW-1], p2_reg};
    assign rsum = 51'((sum + (ProdW+1)'(32768)) >>> 16);

    assign out_free        = !m_valid_reg || m_ready;
    assign status.out_free = out_free;

    always_comb begin
        x1s = cmd.mac_idx[0] ? x1i_reg : x1r_reg;
        us  = cmd.mac_idx[0] ? u_im_reg : u_re_reg;
        ma0 = '0;
        mb0 = '0;
        ma1 = '0;
        mb1 = '0;
        ma2 = '0;
        mb2 = '0;
        case (cmd.op)
            ST_SG_MUL: begin
                ma0 = {1'b0, time_step};
                mb0 = {1'b0, damping};
            end
            ST_SINV_MUL: begin
                ma0 = {1'b0, time_step};
                mb0 = {16'b0, inv_reg};
            end
            ST_S2_MUL: begin
                ma0 = {1'b0, time_step};
                mb0 = {2'b0, sinv_reg};
            end
            ST_C_MUL: begin
                ma0 = {1'b0, stiffness};
                mb0 = {2'b0, sinv_reg};
                ma1 = {1'b0, stiffness};
                mb1 = {2'b0, s2inv_reg};
            end
            ST_MAC: begin
                ma0 = cmd.mac_idx[0] ? {x0i_reg[WordW-1], x0i_reg}
                                     : {x0r_reg[WordW-1], x0r_reg};
                mb0 = cmd.mac_idx[1] ? {2'b0, sinv_reg} : {16'b0, inv_reg};
                ma1 = {x1s[WordW-1], x1s};
                mb1 = cmd.mac_idx[1] ? {c22_reg[WordW-1], c22_reg}
                                     : {c12_reg[WordW-1], c12_reg};
                ma2 = {us[WordW-1], us};
                mb2 = cmd.mac_idx[1] ? {2'b0, s2inv_reg} : {2'b0, sinv_reg};
            end
            default: begin
                ma0 = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p0_reg <= ProdW'(ma0) * ProdW'(mb0);
        p1_reg <= ProdW'(ma1) * ProdW'(mb1);
        p2_reg <= ProdW'(ma2) * ProdW'(mb2);
        case (cmd.op)
            ST_SG_WB: begin
                den_reg <= den_c;
                num_reg <= DivW'(64'h1_0000_0000) + (den_c >> 1);
                rem_reg <= '0;
                inv_reg <= '0;
            end
            ST_DIV: begin
                rem_reg <= ge ? DivW'(rem_sh - {1'b0, den_reg}) : rem_sh[DivW-1:0];
                inv_reg <= {inv_reg[InvW-2:0], ge};
                num_reg <= num_reg << 1;
            end
            ST_SINV_WB: begin
                sinv_reg <= (t0 > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : t0[CoefW-1:0];
            end
            ST_S2_WB: begin
                s2inv_reg <= (t0 > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : t0[CoefW-1:0];
            end
            ST_C_WB: begin
                c12_reg <= (t0[47:31] != '0) ? 32'sh8000_0000 : 32'(32'd0 - t0[31:0]);
                c22_reg <= (d22 < -50'sd2147483648) ? 32'sh8000_0000 : d22[WordW-1:0];
            end
            default: begin
            end
        endcase
        if (cmd.load) begin
            u_re_reg <= s_sample_re;
            u_im_reg <= s_sample_im;
            clip_reg <= 1'b0;
            if (cmd.start) begin
                x0r_reg <= '0;
                x0i_reg <= '0;
                x1r_reg <= '0;
                x1i_reg <= '0;
            end
        end
        if (cmd.mac_issue) begin
            idx_reg <= cmd.mac_idx;
        end
        if (cmd.mac_acc) begin
            if (rsum > SMax) begin
                n_reg[idx_reg] <= 32'sh7FFF_FFFF;
                clip_reg       <= 1'b1;
            end else if (rsum < SMin) begin
                n_reg[idx_reg] <= 32'sh8000_0000;
                clip_reg       <= 1'b1;
            end else begin
                n_reg[idx_reg] <= rsum[WordW-1:0];
            end
        end
        if ((cmd.op == ST_DONE) && out_free) begin
            x0r_reg    <= n_reg[0];
            x0i_reg    <= n_reg[1];
            x1r_reg    <= n_reg[2];
            x1i_reg    <= n_reg[3];
            out_reg[0] <= n_reg[0];
            out_reg[1] <= n_reg[1];
            out_reg[2] <= n_reg[2];
            out_reg[3] <= n_reg[3];
            sat_reg    <= clip_reg;
        end
        if (!aresetn) begin
            x0r_reg <= '0;
            x0i_reg <= '0;
            x1r_reg <= '0;
            x1i_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((cmd.op == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_first_re  = out_reg[0];
    assign m_first_im  = out_reg[1];
    assign m_second_re = out_reg[2];
    assign m_second_im = out_reg[3];
    assign m_saturated = sat_reg;

endmodule

### rtl/damped_oscillator_ssm_scan.sv
// Damped oscillator scan, one channel. A word with known coefficients goes
// from acceptance to result valid in four passes through the three shared
// multipliers; one word is in work at a time, so the next word is accepted
// only once the last one has reached the output, later while a result waits.
// After reset or a register write the first word first rederives the
// coefficients, with a pass through the one-bit-per-cycle divider.
// Synchronous active-low reset sets the config registers to their defaults and the oscillator state to zero.
module damped_oscillator_ssm_scan import dosc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [AddrW-1:0]        paddr,
    input  logic [WordW-1:0]        pwdata,
    output logic [WordW-1:0]        prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [WordW-1:0] s_sample_re,
    input  logic signed [WordW-1:0] s_sample_im,
    input  logic                    s_sequence_start,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [WordW-1:0] m_first_re,
    output logic signed [WordW-1:0] m_first_im,
    output logic signed [WordW-1:0] m_second_re,
    output logic signed [WordW-1:0] m_second_im,
    output logic                    m_saturated
);

    logic [WordW-1:0] stiffness_reg, damping_reg, time_step_reg;
    logic             cfg_write;
    dosc_cmd_t        cmd;
    dosc_status_t     status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg <= '0;
            damping_reg   <= '0;
            time_step_reg <= 32'h0001_0000;
        end else if (cfg_write) begin
            unique case (paddr)
                AddrStiffness: stiffness_reg <= pwdata;
                AddrDamping:   damping_reg   <= pwdata;
                AddrTimeStep:  time_step_reg <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            AddrStiffness: prdata = stiffness_reg;
            AddrDamping:   prdata = damping_reg;
            AddrTimeStep:  prdata = time_step_reg;
            default:       prdata = '0;
        endcase
    end

    dosc_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write        (cfg_write),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sequence_start (s_sequence_start),
        .status           (status),
        .cmd              (cmd)
    );

    dosc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .stiffness   (stiffness_reg),
        .damping     (damping_reg),
        .time_step   (time_step_reg),
        .s_sample_re (s_sample_re),
        .s_sample_im (s_sample_im),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_first_re  (m_first_re),
        .m_first_im  (m_first_im),
        .m_second_re (m_second_re),
        .m_second_im (m_second_im),
        .m_saturated (m_saturated)
    );

endmodule
